// ----- rtl/rchd_pkg.sv -----
// Shared types, widths and helper functions for the rectangle corner
// Hausdorff distance block. Used by every module under rtl/.
`default_nettype none

package rchd_pkg;

  // Field and datapath widths.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int EDGE_W     = COORD_BITS + 1;          // x + width
  localparam int SQR_W      = 2 * EDGE_W;              // one squared gap
  localparam int SQ_W       = SQR_W + 1;               // dx^2 + dy^2
  localparam int SQRT_STEPS = COORD_BITS + 2 + FRAC_BITS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SRC_W      = 2 * SQRT_STEPS;

  // Output field widths and bus widths.
  localparam int DIST_W     = 22;
  localparam int DSQ_W      = 27;
  localparam int IN_W       = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((DIST_W + DSQ_W + 7) / 8) * 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [EDGE_W-1:0]     edge_t;
  typedef logic [SQR_W-1:0]      sqr_t;
  typedef logic [SQ_W-1:0]       sq_t;

  // One input beat.
  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_width;
    coord_t a_height;
    coord_t b_x;
    coord_t b_y;
    coord_t b_width;
    coord_t b_height;
  } rect_pair_t;

  // State carried along the square root chain.
  typedef struct packed {
    logic [SRC_W-1:0]  src;   // radicand digit pairs still to be consumed, top first
    logic [REM_W-1:0]  rem;   // partial remainder
    logic [ROOT_W-1:0] root;  // partial root
    sq_t               sq;    // squared distance, passed through
  } root_t;

  // Gap from coordinate p to the closed interval [lo, hi].
  function automatic edge_t gap(edge_t p, edge_t lo, edge_t hi);
    edge_t g;
    g = '0;
    if (p < lo) begin
      g = lo - p;
    end else if (p > hi) begin
      g = p - hi;
    end
    return g;
  endfunction

  function automatic sq_t min2(sq_t a, sq_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rchd_front.sv -----
// Front end of the distance pipeline: corner gaps, squares, per-direction
// minimum and final maximum, four register stages. Depends on rchd_pkg.
`default_nettype none

module rchd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire rchd_pkg::rect_pair_t pair_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output rchd_pkg::root_t          root_o
);
  import rchd_pkg::*;

  localparam int NSTG = 4;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  // Gaps: index [direction][corner side]; direction 0 is A corners to box B.
  edge_t gx_d [2][2];
  edge_t gy_d [2][2];
  edge_t gx_q [2][2];
  edge_t gy_q [2][2];
  sqr_t  sx_q [2][2];
  sqr_t  sy_q [2][2];
  sq_t   best_d [2];
  sq_t   best_q [2];
  sq_t   sq_q;

  edge_t ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;

  // Stall chain: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 0: rectangle edges and the axis gaps of each corner coordinate.
  always_comb begin
    ax0 = EDGE_W'(pair_i.a_x);
    ay0 = EDGE_W'(pair_i.a_y);
    ax1 = EDGE_W'(pair_i.a_x) + EDGE_W'(pair_i.a_width);
    ay1 = EDGE_W'(pair_i.a_y) + EDGE_W'(pair_i.a_height);
    bx0 = EDGE_W'(pair_i.b_x);
    by0 = EDGE_W'(pair_i.b_y);
    bx1 = EDGE_W'(pair_i.b_x) + EDGE_W'(pair_i.b_width);
    by1 = EDGE_W'(pair_i.b_y) + EDGE_W'(pair_i.b_height);
    gx_d[0][0] = gap(ax0, bx0, bx1);
    gx_d[0][1] = gap(ax1, bx0, bx1);
    gy_d[0][0] = gap(ay0, by0, by1);
    gy_d[0][1] = gap(ay1, by0, by1);
    gx_d[1][0] = gap(bx0, ax0, ax1);
    gx_d[1][1] = gap(bx1, ax0, ax1);
    gy_d[1][0] = gap(by0, ay0, ay1);
    gy_d[1][1] = gap(by1, ay0, ay1);
  end

  // Stage 2 combinational: corner distances and the minimum per direction.
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      best_d[d] = min2(min2(SQ_W'(sx_q[d][0]) + SQ_W'(sy_q[d][0]),
                            SQ_W'(sx_q[d][0]) + SQ_W'(sy_q[d][1])),
                       min2(SQ_W'(sx_q[d][1]) + SQ_W'(sy_q[d][0]),
                            SQ_W'(sx_q[d][1]) + SQ_W'(sy_q[d][1])));
    end
  end

  // Payload registers for the four stages.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (en[1]) begin
      for (int d = 0; d < 2; d++) begin
        for (int s = 0; s < 2; s++) begin
          sx_q[d][s] <= SQR_W'(gx_q[d][s]) * SQR_W'(gx_q[d][s]);
          sy_q[d][s] <= SQR_W'(gy_q[d][s]) * SQR_W'(gy_q[d][s]);
        end
      end
    end
    if (en[2]) begin
      best_q <= best_d;
    end
    if (en[3]) begin
      sq_q <= (best_q[0] > best_q[1]) ? best_q[0] : best_q[1];
    end
  end

  // Seed of the square root chain: radicand scaled by the fraction bits.
  always_comb begin
    root_o.src  = SRC_W'(sq_q) << (2 * FRAC_BITS);
    root_o.rem  = '0;
    root_o.root = '0;
    root_o.sq   = sq_q;
  end

endmodule

`default_nettype wire

// ----- rtl/rchd_sqrt_cell.sv -----
// One cell of the square root chain: resolves one root bit per beat and
// hands its partial result to the next cell. Depends on rchd_pkg.
`default_nettype none

module rchd_sqrt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire rchd_pkg::root_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output rchd_pkg::root_t      data_o
);
  import rchd_pkg::*;

  logic                valid_q;
  logic                en;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                take;
  root_t               data_d;
  root_t               data_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Restoring step: bring down one digit pair, try 4*root+1.
  always_comb begin
    rem_sh      = {data_i.rem, data_i.src[SRC_W-1 -: 2]};
    trial       = {2'b00, data_i.root, 2'b01};
    take        = (rem_sh >= trial);
    data_d.rem  = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    data_d.root = {data_i.root[ROOT_W-2:0], take};
    data_d.src  = {data_i.src[SRC_W-3:0], 2'b00};
    data_d.sq   = data_i.sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rect_corner_hausdorff_distance.sv -----
// Top level of the rectangle corner Hausdorff distance block: the front end
// followed by a chain of square root cells. Depends on rchd_pkg,
// rchd_front and rchd_sqrt_cell.
//
// Usage: each input beat carries two rectangles (x, y, width, height); each
// output beat carries the distance with 8 fraction bits, rounded down, and
// the exact squared distance it came from. One output beat per input beat,
// in order.
// Path: an accepted input beat passes four front-end stages (gaps, squares,
// minimum, maximum) and then one cell per root bit, 22 cells, before tvalid
// rises on the output.
// Throughput: one beat per cycle unless the output stalls; every stage is a
// register with its own valid bit; beats follow each other through the chain.
// Stall: while the output beat is not taken it holds, and the stages behind
// it keep moving until they are full; s_axis_tready falls only once all 26
// stages hold a beat.
// Reset: rst_ni clears all valid bits; the block is ready right after.
`default_nettype none

module rect_corner_hausdorff_distance (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height (12 bits each)
  input  wire logic [rchd_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // distance_q8 (22 bits), distance_squared (27 bits), zero pad
  output logic [rchd_pkg::OUT_W-1:0]      m_axis_tdata
);
  import rchd_pkg::*;

  rect_pair_t pair;
  logic       cv [SQRT_STEPS+1];
  logic       cr [SQRT_STEPS+1];
  root_t      cd [SQRT_STEPS+1];

  // Unpack the input beat, first field in the lowest bits.
  always_comb begin
    pair.a_x      = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
    pair.a_y      = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
    pair.a_width  = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
    pair.a_height = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
    pair.b_x      = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
    pair.b_y      = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
    pair.b_width  = s_axis_tdata[6*COORD_BITS +: COORD_BITS];
    pair.b_height = s_axis_tdata[7*COORD_BITS +: COORD_BITS];
  end

  // Squared distance front end.
  rchd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .pair_i  (pair),
    .valid_o (cv[0]),
    .ready_i (cr[0]),
    .root_o  (cd[0])
  );

  // Square root chain, one root bit per cell.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
    rchd_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .ready_o (cr[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .ready_i (cr[i+1]),
      .data_o  (cd[i+1])
    );
  end

  // The last cell's register is the output register.
  assign cr[SQRT_STEPS] = m_axis_tready;
  assign m_axis_tvalid  = cv[SQRT_STEPS];
  assign m_axis_tdata   = OUT_W'({DSQ_W'(cd[SQRT_STEPS].sq), DIST_W'(cd[SQRT_STEPS].root)});

  // Input can only be held off when every stage is full and the output stalls.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  // A zero squared distance gives a zero root.
  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (cd[SQRT_STEPS].sq == '0)) |-> (cd[SQRT_STEPS].root == '0))
    else $error("nonzero root for zero squared distance");

  // A nonzero squared distance is at least one, so the root is at least one.
  a_nonzero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (cd[SQRT_STEPS].sq != '0)) |->
      (cd[SQRT_STEPS].root >= (ROOT_W'(1) << FRAC_BITS)))
    else $error("root below one for nonzero squared distance");

endmodule

`default_nettype wire
